// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/fadd_pkg.sv =====
`timescale 1ns / 1ps
package fadd_pkg;
  localparam int EXP_BITS = 8;
  localparam logic [EXP_BITS-1:0] EXP_MAX = '1;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } fadd_cmd_t;

  typedef struct packed {
    logic done;
  } fadd_status_t;
endpackage

// ===== rtl/core/float32_adder_truncating.sv =====
`timescale 1ns / 1ps
// Truncating single-precision adder: a request needs only the load step when an operand is zero
// or negligible, and more steps when cancellation needs left
// normalization, one bit per cycle in the normalizing shifter; one request is in work at a time.
module float32_adder_truncating #(
  parameter int FRACTION_BITS = 23
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [FRACTION_BITS+fadd_pkg::EXP_BITS:0] operand_a,
  input  logic [FRACTION_BITS+fadd_pkg::EXP_BITS:0] operand_b,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [FRACTION_BITS+fadd_pkg::EXP_BITS:0] sum_bits
);
  import fadd_pkg::*;

  fadd_cmd_t    cmd;
  fadd_status_t status;

  fadd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  fadd_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
    .sum_bits(sum_bits), .status(status)
  );
endmodule

// ===== rtl/core/fadd_ctrl.sv =====
`timescale 1ns / 1ps
module fadd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  fadd_pkg::fadd_status_t status,
  output fadd_pkg::fadd_cmd_t    cmd
);
  import fadd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WORK = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        if (status.done) begin
          cmd.emit = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== rtl/core/fadd_dp.sv =====
`timescale 1ns / 1ps
module fadd_dp #(
  parameter int FRACTION_BITS = 23
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fadd_pkg::fadd_cmd_t                   cmd,
  input  logic [FRACTION_BITS+fadd_pkg::EXP_BITS:0] operand_a,
  input  logic [FRACTION_BITS+fadd_pkg::EXP_BITS:0] operand_b,
  output logic [FRACTION_BITS+fadd_pkg::EXP_BITS:0] sum_bits,
  output fadd_pkg::fadd_status_t                status
);
  import fadd_pkg::*;

  localparam int W = FRACTION_BITS + EXP_BITS + 1;
  localparam int SIGN_POS = W - 1;
  localparam int SW = FRACTION_BITS + 2;

  // The first cycle aligns and adds; then one left shift per cycle normalizes.
  logic [W-1:0]              result;
  logic                      fin;
  logic [SW-1:0]             mag;
  logic [EXP_BITS-1:0]       ez;
  logic                      neg;

  logic [W-2:0]              mx, my;
  logic                      sgx, sgy;
  logic [EXP_BITS-1:0]       ex, ey, d;
  logic [SW-1:0]             sx, sy, sxa, sya, m0;
  logic                      xsmall, drop;
  logic [EXP_BITS:0]         ez1;

  always_comb begin
    mx  = operand_a[W-2:0];
    my  = operand_b[W-2:0];
    sgx = operand_a[SIGN_POS];
    sgy = operand_b[SIGN_POS];
    ex  = operand_a[W-2 -: EXP_BITS];
    ey  = operand_b[W-2 -: EXP_BITS];
    sx  = {2'b01, operand_a[FRACTION_BITS-1:0]};
    sy  = {2'b01, operand_b[FRACTION_BITS-1:0]};
    xsmall = (ex < ey);
    d   = xsmall ? (ey - ex) : (ex - ey);
    drop = ({1'b0, d} > (EXP_BITS+1)'(FRACTION_BITS));
    sxa = xsmall ? (sx >> d) : sx;
    sya = xsmall ? sy : (sy >> d);
    if (sgx == sgy) begin
      m0 = sxa + sya;
      neg = sgx;
    end else if (sxa >= sya) begin
      m0 = sxa - sya;
      neg = sgx;
    end else begin
      m0 = sya - sxa;
      neg = sgy;
    end
    ez1 = {1'b0, (xsmall ? ey : ex)} + (EXP_BITS+1)'(m0[SW-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin <= 1'b0;
    end else if (cmd.load) begin
      if (mx == '0) begin
        result <= operand_b; fin <= 1'b1;
      end else if (my == '0) begin
        result <= operand_a; fin <= 1'b1;
      end else if (drop) begin
        result <= xsmall ? operand_b : operand_a; fin <= 1'b1;
      end else if (m0 == '0) begin
        result <= '0; fin <= 1'b1;
      end else if (ez1[EXP_BITS]) begin
        result <= {neg, EXP_MAX, {FRACTION_BITS{1'b0}}}; fin <= 1'b1;
      end else begin
        mag <= m0[SW-1] ? (m0 >> 1) : m0;
        ez  <= ez1[EXP_BITS-1:0];
        result <= {neg, {(W-1){1'b0}}};
        fin <= 1'b0;
      end
    end else if (cmd.step) begin
      if (mag[FRACTION_BITS]) begin
        result <= {result[SIGN_POS], ez, mag[FRACTION_BITS-1:0]};
        fin <= 1'b1;
      end else if (ez <= EXP_BITS'(1)) begin
        result <= '0; fin <= 1'b1;
      end else begin
        mag <= mag << 1;
        ez  <= ez - EXP_BITS'(1);
      end
    end else if (cmd.emit) begin
      sum_bits <= result;
    end
  end

  assign status.done = fin;
endmodule

// ===== rtl/core/fadd_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fadd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  `ASSERT_IMPLIES(a_not_both, clk, rst, out_valid, !in_ready)
  `ASSERT_NEXT(a_no_instant, clk, rst, in_valid && in_ready, !out_valid)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_free_after, clk, rst, out_valid && out_ready, in_ready)
endmodule

bind float32_adder_truncating fadd_checker u_fadd_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready)
);
